/* hw/rtl/supq_pkg.sv */
// supq_pkg: shared constants and control types for the sorted unique priority queue
// no dependencies; used by the interfaces, controller, datapath and top level
package supq_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // response status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DUP   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic                ins;    // commit insert
    logic                rem;    // commit remove
    logic                load;   // capture response
    logic [STATUS_W-1:0] code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic dup;
  } flags_t;

endpackage

/* hw/rtl/supq_if.sv */
// supq_in_if / supq_out_if: valid-ready channels for requests and responses
// depends on supq_pkg for field widths
interface supq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic signed [supq_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface supq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [supq_pkg::STATUS_W-1:0] status;
  logic signed [supq_pkg::VALUE_W-1:0]  removed_value;
  logic        [supq_pkg::COUNT_W-1:0]  count;
  logic                                 is_empty;
  logic                                 is_full;

  modport source (output valid, output status, output removed_value, output count,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input removed_value, input count,
                  input is_empty, input is_full, output ready);
endinterface

/* hw/rtl/supq_ctrl.sv */
// supq_ctrl: handshake controller, decides the outcome of each request
// depends on supq_pkg for command/flag types and status codes
module supq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_req_type,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  input  supq_pkg::flags_t     flags,
  output supq_pkg::cmd_t       cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_r, state_nxt;
  logic accept;

  // a new request is taken whenever the response slot is free or draining
  assign in_ready  = (state_r == S_IDLE) || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = (state_r == S_HOLD);

  always_comb begin
    cmd      = '0;
    cmd.load = accept;
    if (in_req_type == supq_pkg::REQ_INSERT) begin
      if (flags.full) begin
        cmd.code = supq_pkg::STAT_FULL;
      end else if (flags.dup) begin
        cmd.code = supq_pkg::STAT_DUP;
      end else begin
        cmd.code = supq_pkg::STAT_OK;
        cmd.ins  = accept;
      end
    end else begin
      if (flags.empty) begin
        cmd.code = supq_pkg::STAT_EMPTY;
      end else begin
        cmd.code = supq_pkg::STAT_OK;
        cmd.rem  = accept;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready && !accept) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/supq_dp.sv */
// supq_dp: row of sorted entry cells, stored count and response register
// depends on supq_pkg for command/flag types and field widths
module supq_dp #(
  parameter int CAPACITY = supq_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [supq_pkg::VALUE_W-1:0]  in_value,
  input  supq_pkg::cmd_t                       cmd,
  output supq_pkg::flags_t                     flags,
  output logic        [supq_pkg::STATUS_W-1:0] out_status,
  output logic signed [supq_pkg::VALUE_W-1:0]  out_removed_value,
  output logic        [supq_pkg::COUNT_W-1:0]  out_count,
  output logic                                 out_is_empty,
  output logic                                 out_is_full
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = supq_pkg::VALUE_W;

  logic signed [VW-1:0]           entry_r [CAPACITY];
  logic [CAPACITY-1:0][VW-1:0]    entry_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [CAPACITY-1:0]            active, eq, gt;

  logic [supq_pkg::STATUS_W-1:0] status_r;
  logic signed [VW-1:0]          removed_r;
  logic [supq_pkg::COUNT_W-1:0]  ocount_r;
  logic                          empty_r, full_r;

  // every cell compares its own value against the request at once
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
    assign active[i] = (CW'(i) < count_r);
    assign eq[i]     = active[i] && (entry_r[i] == in_value);
    assign gt[i]     = active[i] && (entry_r[i] > in_value);
  end

  assign flags.full  = (count_r == CW'(CAPACITY));
  assign flags.empty = (count_r == '0);
  assign flags.dup   = |eq;

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) count_nxt = count_r + CW'(1);
    else if (cmd.rem) count_nxt = count_r - CW'(1);
  end

  // insert: larger cells take their lower neighbour, the boundary cell takes the value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 from_below;
    logic                 take;
    logic signed [VW-1:0] below_val;
    logic signed [VW-1:0] above_val;
    if (i == 0) begin : g_first
      assign from_below = 1'b0;
      assign below_val  = in_value;
    end else begin : g_rest
      assign from_below = gt[i-1];
      assign below_val  = entry_r[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign above_val = entry_r[i];
    end else begin : g_inner
      assign above_val = entry_r[i+1];
    end
    assign take = gt[i] || (count_r == CW'(i));

    assign entry_nxt[i] = (cmd.ins && take) ? (from_below ? below_val : in_value) :
                          cmd.rem           ? above_val :
                                              entry_r[i];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      entry_r[i] <= entry_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r  <= cmd.code;
      removed_r <= cmd.rem ? entry_r[0] : '0;
      ocount_r  <= supq_pkg::COUNT_W'(count_nxt);
      empty_r   <= (count_nxt == '0);
      full_r    <= (count_nxt == CW'(CAPACITY));
    end
  end

  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_count         = ocount_r;
  assign out_is_empty      = empty_r;
  assign out_is_full       = full_r;

endmodule

/* hw/rtl/sorted_unique_priority_queue_top.sv */
// sorted_unique_priority_queue_top: sorted unique priority queue, top level
// depends on supq_pkg, supq_if, supq_ctrl, supq_dp
//
//   channel   dir   beat fields
//   in_chan   in    req_type, value
//   out_chan  out   status, removed_value, count, is_empty, is_full
//
// one request per cycle: every cell compares and shifts in the same cycle, so the
// response is registered and appears in the cycle after the request beat is taken
// a new request is taken while a response waits if that response leaves the same cycle
// a stalled response holds in_chan.ready low until it is taken
// reset clears the stored count and the controller state only; no clearing pass
module sorted_unique_priority_queue_top #(
  parameter int CAPACITY = supq_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  supq_in_if.sink        in_chan,
  supq_out_if.source     out_chan
);

  supq_pkg::cmd_t   cmd;
  supq_pkg::flags_t flags;

  supq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_req_type (in_chan.req_type),
    .in_ready    (in_chan.ready),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .flags       (flags),
    .cmd         (cmd)
  );

  supq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_value          (in_chan.value),
    .cmd               (cmd),
    .flags             (flags),
    .out_status        (out_chan.status),
    .out_removed_value (out_chan.removed_value),
    .out_count         (out_chan.count),
    .out_is_empty      (out_chan.is_empty),
    .out_is_full       (out_chan.is_full)
  );

  // every taken request yields a response next cycle
  a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> out_chan.valid)
    else $error("no response after accepted request");

  // a refused response never carries a removed value
  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status != supq_pkg::STAT_OK && out_chan.removed_value != '0
    |-> 1'b0)
    else $error("removed value on refused request");

  // empty and full are exclusive
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !(out_chan.is_empty && out_chan.is_full))
    else $error("empty and full both set");

  // a successful remove never reports a full queue
  a_remove_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem |=> !out_chan.is_full)
    else $error("full after remove");

endmodule
